FILE: hdl/assert_macros.svh
// Assertion macros shared by the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define LPHT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define LPHT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `LPHT_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

FILE: hdl/lpht_pkg.sv
// Shared types, codes and defaults for the linear probing hash table.
`default_nettype none

package lpht_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int FIFO_DEPTH_DEF = 2;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int MARK_W   = 2;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Response status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // Slot marks
    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    // Classified request as it travels from front end to back end
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } item_t;

endpackage

`default_nettype wire

FILE: hdl/lpht_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/lpht_fifo.sv
// Short request queue between the hashing front end and the probing back end.
`default_nettype none
`include "assert_macros.svh"

module lpht_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `LPHT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "fifo count above depth")
    `LPHT_ASSERT_NEVER(a_empty_ptrs, clk, rst_n, (count_reg == '0) && (wr_ptr_reg != rd_ptr_reg), "fifo empty with pointers apart")

endmodule

`default_nettype wire

FILE: hdl/lpht_front.sv
// Front end: takes requests, normalizes the key and computes the home slot.
`default_nettype none
`include "assert_macros.svh"

module lpht_front
    import lpht_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     enable,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    input  wire logic [OP_W-1:0]          op,
    input  wire logic [KEY_W-1:0]         key,
    input  wire logic [PAY_W-1:0]         payload,
    output logic                          push_valid,
    input  wire logic                     push_ready,
    output item_t                         push_item,
    output logic      [$clog2(SLOTS)-1:0] push_home
);

    localparam int SW     = $clog2(SLOTS);
    localparam int AW     = $clog2(SLOTS + 255);   // h + c
    localparam int PW     = AW + 8;                // (h + c) * c
    localparam int RSHIFT = PW + SW;
    localparam int MW     = PW + RSHIFT;
    localparam logic [RSHIFT-1:0] RECIP = RSHIFT'((64'd1 << RSHIFT) / SLOTS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_RECIP = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;

    logic [2:0]       state_reg, state_next;
    item_t            item_reg, item_next;
    logic [KEY_W-1:0] sh_reg, sh_next;
    logic [SW-1:0]    h_reg, h_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [PW-1:0]    quot_reg, quot_next;

    logic [KEY_W-1:0] canon;
    logic             alive;
    logic [AW-1:0]    sum_w;
    logic [MW-1:0]    recip_prod;
    logic [PW-1:0]    rem_raw;
    logic [PW-1:0]    rem_fix;

    // Key cut to KEY_BYTES, everything from the first zero byte cleared
    always_comb
    begin
        alive = 1'b1;
        canon = '0;
        for (int i = 0; i < 8; i++)
        begin
            if ((i >= KEY_BYTES) || (key[8*i +: 8] == 8'd0))
            begin
                alive = 1'b0;
            end
            canon[8*i +: 8] = alive ? key[8*i +: 8] : 8'd0;
        end
    end

    assign sum_w      = AW'(h_reg) + AW'(sh_reg[7:0]);
    assign recip_prod = MW'(prod_reg) * MW'(RECIP);
    assign rem_raw    = prod_reg - PW'(quot_reg * PW'(SLOTS));
    assign rem_fix    = (rem_raw >= PW'(SLOTS)) ? rem_raw - PW'(SLOTS) : rem_raw;

    assign req_ready  = enable && (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_item  = item_reg;
    assign push_home  = h_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        sh_next    = sh_reg;
        h_next     = h_reg;
        prod_next  = prod_reg;
        quot_next  = quot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    item_next.op      = op;
                    item_next.key     = canon;
                    item_next.payload = payload;
                    sh_next           = canon;
                    h_next            = '0;
                    state_next        = (canon[7:0] == 8'd0) ? ST_PUSH : ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PW'(sum_w) * PW'(sh_reg[7:0]);
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                quot_next  = recip_prod[MW-1:RSHIFT];
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                h_next     = rem_fix[SW-1:0];
                sh_next    = sh_reg >> 8;
                state_next = (sh_reg[15:8] == 8'd0) ? ST_PUSH : ST_MUL;
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        sh_reg   <= sh_next;
        h_reg    <= h_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
    end

    `LPHT_ASSERT(a_hash_byte, clk, rst_n, (state_reg == ST_MUL) |-> (sh_reg[7:0] != 8'd0), "hash step on a zero byte")

endmodule

`default_nettype wire

FILE: hdl/lpht_back.sv
// Back end: probes the slot memories and writes the response register.
`default_nettype none
`include "assert_macros.svh"

module lpht_back
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    output logic                          active,
    input  wire logic                     pop_valid,
    output logic                          pop_ready,
    input  wire item_t                    pop_item,
    input  wire logic [$clog2(SLOTS)-1:0] pop_home,
    output logic                          rsp_valid,
    input  wire logic                     rsp_ready,
    output logic      [STATUS_W-1:0]      status,
    output logic      [SLOT_W-1:0]        slot,
    output logic      [PAY_W-1:0]         payload_out
);

    localparam int SW = $clog2(SLOTS);
    localparam int DW = KEY_W + PAY_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [SW-1:0]       clr_reg, clr_next;
    item_t               req_reg, req_next;
    logic [SW-1:0]       t_reg, t_next;
    logic [SW-1:0]       probes_reg, probes_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [PAY_W-1:0]    pay_out_reg, pay_out_next;

    logic [MARK_W-1:0]   mark_rd;
    logic [DW-1:0]       data_rd;
    logic [KEY_W-1:0]    key_rd;
    logic [PAY_W-1:0]    pay_rd;
    logic                mark_we;
    logic [SW-1:0]       mark_waddr;
    logic [MARK_W-1:0]   mark_wdata;
    logic                data_we;
    logic [SW-1:0]       raddr;

    logic [SW-1:0]       t_inc;
    logic                last;
    logic                out_free;
    logic                done;
    logic                hit;
    logic                advance;
    logic                want_mark_we;
    logic [MARK_W-1:0]   want_mark;
    logic                want_data_we;
    logic [STATUS_W-1:0] fin_status;
    logic [PAY_W-1:0]    fin_pay;
    logic [SW+3:0]       slot_ext;

    lpht_ram #(
        .WIDTH (MARK_W),
        .DEPTH (SLOTS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (raddr),
        .rdata (mark_rd)
    );

    lpht_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (t_reg),
        .wdata ({req_reg.key, req_reg.payload}),
        .raddr (raddr),
        .rdata (data_rd)
    );

    assign key_rd   = data_rd[DW-1:PAY_W];
    assign pay_rd   = data_rd[PAY_W-1:0];
    assign t_inc    = (t_reg == SW'(SLOTS - 1)) ? '0 : t_reg + 1'b1;
    assign last     = (probes_reg == SW'(SLOTS - 1));
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign slot_ext = {4'd0, t_reg};
    assign active   = (state_reg != ST_CLEAR);

    // Decision for the slot whose mark and data came back this cycle
    always_comb
    begin
        done         = 1'b0;
        hit          = 1'b0;
        advance      = 1'b0;
        want_mark_we = 1'b0;
        want_mark    = MARK_USED;
        want_data_we = 1'b0;
        fin_status   = STATUS_NOT_FOUND;
        fin_pay      = '0;
        unique case (req_reg.op)
            OP_INSERT:
            begin
                if (mark_rd != MARK_USED)
                begin
                    done         = 1'b1;
                    hit          = 1'b1;
                    want_mark_we = 1'b1;
                    want_data_we = 1'b1;
                    fin_status   = STATUS_OK;
                end
                else if (last)
                begin
                    done       = 1'b1;
                    fin_status = STATUS_FULL;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            OP_LOOKUP, OP_DELETE:
            begin
                if (mark_rd == MARK_EMPTY)
                begin
                    done = 1'b1;
                end
                else if ((mark_rd == MARK_USED) && (key_rd == req_reg.key))
                begin
                    done         = 1'b1;
                    hit          = 1'b1;
                    fin_status   = STATUS_OK;
                    fin_pay      = pay_rd;
                    want_mark_we = (req_reg.op == OP_DELETE);
                    want_mark    = MARK_DELETED;
                end
                else if (last)
                begin
                    done = 1'b1;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        t_next         = t_reg;
        probes_next    = probes_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        pay_out_next   = pay_out_reg;
        pop_ready      = 1'b0;
        mark_we        = 1'b0;
        mark_waddr     = t_reg;
        mark_wdata     = want_mark;
        data_we        = 1'b0;
        raddr          = t_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                mark_wdata = MARK_EMPTY;
                if (clr_reg == SW'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                raddr     = pop_home;
                if (pop_valid)
                begin
                    req_next    = pop_item;
                    t_next      = pop_home;
                    probes_next = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (advance)
                begin
                    raddr       = t_inc;
                    t_next      = t_inc;
                    probes_next = probes_reg + 1'b1;
                end
                else if (done && out_free)
                begin
                    mark_we        = want_mark_we;
                    data_we        = want_data_we;
                    rsp_valid_next = 1'b1;
                    status_next    = fin_status;
                    slot_next      = hit ? slot_ext[3:0] : '0;
                    pay_out_next   = fin_pay;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        t_reg       <= t_next;
        probes_reg  <= probes_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        pay_out_reg <= pay_out_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign payload_out = pay_out_reg;

    `LPHT_ASSERT(a_clear_once, clk, rst_n,
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR),
        "slot clear pass restarted")
    `LPHT_ASSERT(a_rsp_from_check, clk, rst_n,
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_CHECK),
        "response raised outside probe")

endmodule

`default_nettype wire

FILE: hdl/linear_probe_hash_table.sv
// Top level of the linear probing hash table: front end, queue, back end.
//
// Request channel (req_valid/req_ready): op, key, payload. One transaction
// is one insert, lookup or delete. The key is cut to KEY_BYTES bytes and
// ends at its first zero byte. Response channel (rsp_valid/rsp_ready):
// status, slot, payload_out, exactly one transaction per request, in order.
//
// Front end hashes the key's leading nonzero bytes (at most KEY_BYTES), each
// in turn by multiply, reciprocal multiply and remainder correction. A
// 2-deep queue sits behind it. Back end probes one slot per cycle through the
// registered-read slot RAMs: a pop, then 1 to SLOTS probes, set by the probe
// chain length. Front end and back end work on different requests at once;
// the sustained rate is set by the slower of the two.
// Reset: a clearing pass writes every slot mark empty, one slot a cycle;
// req_ready stays low until it is done.
// When the receiver stalls the response register holds; the back end waits
// with its finished result, and the queue and front end keep taking requests
// until the queue fills.
`default_nettype none

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [PAY_W-1:0]    payload,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic      [STATUS_W-1:0] status,
    output logic      [SLOT_W-1:0]   slot,
    output logic      [PAY_W-1:0]    payload_out
);

    localparam int SW = $clog2(SLOTS);
    localparam int QW = $bits(item_t) + SW;

    logic          active;
    logic          push_valid;
    logic          push_ready;
    item_t         push_item;
    logic [SW-1:0] push_home;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;
    item_t         pop_item;
    logic [SW-1:0] pop_home;

    // Hash front end: normalized key plus home slot
    lpht_front #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (active),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .op         (op),
        .key        (key),
        .payload    (payload),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .push_home  (push_home)
    );

    // Decoupling queue
    lpht_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH_DEF)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_item, push_home}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_item = item_t'(pop_data[QW-1:SW]);
    assign pop_home = pop_data[SW-1:0];

    // Probe back end with slot memories and response register
    lpht_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .active      (active),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .pop_home    (pop_home),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .slot        (slot),
        .payload_out (payload_out)
    );

endmodule

`default_nettype wire
